FILE: rtl/core/nns_pkg.sv
`default_nettype none

package nns_pkg;

    // Line store and scale limits.
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_FACTOR  = 16;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = 13;
    localparam int FAC_W       = 5;
    localparam int PH_W        = $clog2(MAX_FACTOR);

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = WID_W;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH = 2'd2;

    // Field codes.
    localparam logic CMD_PIXEL    = 1'b0;
    localparam logic CMD_TICK     = 1'b1;
    localparam logic MODE_ENLARGE = 1'b0;
    localparam logic MODE_SHRINK  = 1'b1;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       cmd;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       end_of_line;
        logic [1:0] pad_bytes;
        logic       last;
    } out_item_t;

    // One run of identical output pixels.
    typedef struct packed {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [FAC_W-1:0] count;
        logic             eol;
        logic [1:0]       pad;
    } job_t;

    // Effective configuration and the values derived from it.
    typedef struct packed {
        logic             mode;
        logic [FAC_W-1:0] factor;
        logic [WID_W-1:0] width;
        logic [1:0]       pad_up;
        logic [1:0]       pad_down;
        logic [COL_W-1:0] last_kept;
        logic [PH_W-1:0]  col_mod;
        logic [PH_W-1:0]  row_wrap;
        logic             load;
        logic             busy;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [PH_W-1:0]  row_phase;
    } fe_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/nns_setup.sv
`default_nettype none

module nns_setup (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nns_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire nns_pkg::fe_status_t            status,
    output nns_pkg::cfg_t                       cfg
);
    import nns_pkg::*;

    localparam int STEP_W = $clog2(WID_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WID_W - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [1:0] OP_COL = 2'd0;
    localparam logic [1:0] OP_WID = 2'd1;
    localparam logic [1:0] OP_ROW = 2'd2;

    logic             mode_reg;
    logic [FAC_W-1:0] factor_reg;
    logic [WID_W-1:0] width_reg;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PH_W-1:0]   rem_reg, rem_next;
    logic [WID_W-1:0]  quo_reg, quo_next;
    logic [PH_W-1:0]   col_mod_reg, col_mod_next;
    logic [PH_W-1:0]   row_wrap_reg, row_wrap_next;
    logic [WID_W-1:0]  qw_reg, qw_next;
    logic [COL_W-1:0]  last_kept_reg, last_kept_next;
    logic [1:0]        pad_down_reg, pad_down_next;

    logic [FAC_W-1:0]       f_eff;
    logic [WID_W-1:0]       w_eff;
    logic [WID_W-1:0]       dividend;
    logic [FAC_W-1:0]       rem_sh;
    logic                   fits;
    logic [FAC_W-1:0]       rem_diff;
    logic [PH_W-1:0]        rem_new;
    logic [WID_W-1:0]       quo_new;
    logic [WID_W+FAC_W-1:0] kept_prod;
    logic [WID_W-1:0]       out_w;
    logic [3:0]             pad_up_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ENLARGE;
            factor_reg <= FAC_W'(1);
            width_reg  <= WID_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg   <= cfg_data[0];
                REG_FACTOR:   factor_reg <= cfg_data[FAC_W-1:0];
                REG_IN_WIDTH: width_reg  <= cfg_data[WID_W-1:0];
                default:      ;
            endcase
        end
    end

    // Out-of-range settings are clamped.
    always_comb
    begin
        if (factor_reg == '0)
            f_eff = FAC_W'(1);
        else if (factor_reg > FAC_W'(MAX_FACTOR))
            f_eff = FAC_W'(MAX_FACTOR);
        else
            f_eff = factor_reg;

        if (width_reg == '0)
            w_eff = WID_W'(1);
        else if (width_reg > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
    end

    // Restoring division by the factor, one quotient bit per cycle.
    always_comb
    begin
        case (op_reg)
            OP_COL:  dividend = {1'b0, status.column};
            OP_WID:  dividend = w_eff - WID_W'(1);
            OP_ROW:  dividend = WID_W'(status.row_phase) + WID_W'(1);
            default: dividend = '0;
        endcase
    end

    assign rem_sh   = {rem_reg, dividend[step_reg]};
    assign fits     = (rem_sh >= f_eff);
    assign rem_diff = rem_sh - f_eff;
    assign rem_new  = fits ? rem_diff[PH_W-1:0] : rem_sh[PH_W-1:0];
    assign quo_new  = {quo_reg[WID_W-2:0], fits};

    assign kept_prod   = (WID_W+FAC_W)'(qw_reg) * (WID_W+FAC_W)'(f_eff);
    assign out_w       = qw_reg + WID_W'(1);
    assign pad_up_prod = {2'b00, w_eff[1:0]} * {2'b00, f_eff[1:0]};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        col_mod_next   = col_mod_reg;
        row_wrap_next  = row_wrap_reg;
        qw_next        = qw_reg;
        last_kept_next = last_kept_reg;
        pad_down_next  = pad_down_reg;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_RUN:
            begin
                rem_next  = rem_new;
                quo_next  = quo_new;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    rem_next  = '0;
                    quo_next  = '0;
                    step_next = STEP_LAST;
                    case (op_reg)
                        OP_COL:  col_mod_next  = rem_new;
                        OP_WID:  qw_next       = quo_new;
                        OP_ROW:  row_wrap_next = rem_new;
                        default: ;
                    endcase
                    if (op_reg == OP_ROW)
                        state_next = ST_FINISH;
                    else
                        op_next = op_reg + 2'd1;
                end
            end
            ST_FINISH:
            begin
                last_kept_next = kept_prod[COL_W-1:0];
                pad_down_next  = out_w[1:0];
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            state_next = ST_RUN;
            op_next    = OP_COL;
            step_next  = STEP_LAST;
            rem_next   = '0;
            quo_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_COL;
            step_reg      <= STEP_LAST;
            rem_reg       <= '0;
            quo_reg       <= '0;
            col_mod_reg   <= '0;
            row_wrap_reg  <= '0;
            qw_reg        <= '0;
            last_kept_reg <= '0;
            pad_down_reg  <= 2'd1;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            col_mod_reg   <= col_mod_next;
            row_wrap_reg  <= row_wrap_next;
            qw_reg        <= qw_next;
            last_kept_reg <= last_kept_next;
            pad_down_reg  <= pad_down_next;
        end
    end

    assign cfg.mode      = mode_reg;
    assign cfg.factor    = f_eff;
    assign cfg.width     = w_eff;
    assign cfg.pad_up    = pad_up_prod[1:0];
    assign cfg.pad_down  = pad_down_reg;
    assign cfg.last_kept = last_kept_reg;
    assign cfg.col_mod   = col_mod_reg;
    assign cfg.row_wrap  = row_wrap_reg;
    assign cfg.load      = (state_reg == ST_FINISH);
    assign cfg.busy      = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/nns_front.sv
`default_nettype none

module nns_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pixel_valid,
    input  wire nns_pkg::in_item_t           pixel,
    output logic                             pixel_stall,
    input  wire nns_pkg::cfg_t               cfg,
    input  wire logic [nns_pkg::QCNT_W-1:0]  queue_count,
    output nns_pkg::fe_status_t              status,
    output logic                             job_valid,
    output nns_pkg::job_t                    job
);
    import nns_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [PH_W-1:0]  col_mod_reg, col_mod_next;
    logic [PH_W-1:0]  row_reg, row_next;
    logic             reduced_reg, reduced_next;
    logic [PH_W-1:0]  replays_reg, replays_next;
    logic [COL_W-1:0] rcol_reg, rcol_next;

    logic             s1_valid_reg;
    job_t             s1_job_reg;
    logic             s1_mem_reg;
    logic [23:0]      rd_data_reg;
    logic [23:0]      line_mem [MAX_WIDTH];

    logic [QCNT_W:0]  used;
    logic             accept;
    logic             col_last;
    logic             rcol_last;
    logic             keep;
    logic             kept_eol;
    logic [PH_W-1:0]  col_mod_inc;
    logic [PH_W-1:0]  row_inc;
    logic             emit;
    logic             use_mem;
    logic             mem_we;
    job_t             jb;

    // A slot is held for the item in the read stage as well.
    assign used        = (QCNT_W+1)'(queue_count) + (QCNT_W+1)'(s1_valid_reg);
    assign pixel_stall = cfg.busy || (used >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept      = pixel_valid && !pixel_stall;

    assign col_last  = (({1'b0, col_reg} + WID_W'(1)) >= cfg.width);
    assign rcol_last = (({1'b0, rcol_reg} + WID_W'(1)) >= cfg.width);
    assign keep      = (row_reg == '0) && (col_mod_reg == '0);
    assign kept_eol  = col_last || (col_reg == cfg.last_kept);

    assign col_mod_inc = (({1'b0, col_mod_reg} + FAC_W'(1)) == cfg.factor) ?
                         '0 : col_mod_reg + PH_W'(1);

    // Until the first wrap after a factor change the phase may exceed the
    // factor, so the wrapped value computed by the setup unit is used once.
    always_comb
    begin
        if (reduced_reg)
            row_inc = (({1'b0, row_reg} + FAC_W'(1)) == cfg.factor) ?
                      '0 : row_reg + PH_W'(1);
        else
            row_inc = cfg.row_wrap;
    end

    always_comb
    begin
        col_next     = col_reg;
        col_mod_next = col_mod_reg;
        row_next     = row_reg;
        reduced_next = reduced_reg;
        replays_next = replays_reg;
        rcol_next    = rcol_reg;
        emit         = 1'b0;
        use_mem      = 1'b0;
        mem_we       = 1'b0;
        jb.blue      = pixel.blue;
        jb.green     = pixel.green;
        jb.red       = pixel.red;
        jb.count     = cfg.factor;
        jb.eol       = col_last;
        jb.pad       = cfg.pad_up;

        if (accept)
        begin
            if (cfg.mode == MODE_ENLARGE)
            begin
                if (pixel.cmd == CMD_PIXEL)
                begin
                    if (replays_reg == '0)
                    begin
                        emit   = 1'b1;
                        mem_we = 1'b1;
                        if (col_last)
                        begin
                            col_next     = '0;
                            col_mod_next = '0;
                            replays_next = PH_W'(cfg.factor - FAC_W'(1));
                            rcol_next    = '0;
                        end
                        else
                        begin
                            col_next     = col_reg + COL_W'(1);
                            col_mod_next = col_mod_inc;
                        end
                    end
                end
                else
                begin
                    if (replays_reg != '0)
                    begin
                        emit    = 1'b1;
                        use_mem = 1'b1;
                        jb.eol  = rcol_last;
                        if (rcol_last)
                        begin
                            rcol_next    = '0;
                            replays_next = replays_reg - PH_W'(1);
                        end
                        else
                        begin
                            rcol_next = rcol_reg + COL_W'(1);
                        end
                    end
                end
            end
            else
            begin
                if (pixel.cmd == CMD_PIXEL)
                begin
                    emit     = keep;
                    jb.count = FAC_W'(1);
                    jb.eol   = kept_eol;
                    jb.pad   = cfg.pad_down;
                    if (col_last)
                    begin
                        col_next     = '0;
                        col_mod_next = '0;
                        row_next     = row_inc;
                        reduced_next = 1'b1;
                    end
                    else
                    begin
                        col_next     = col_reg + COL_W'(1);
                        col_mod_next = col_mod_inc;
                    end
                end
            end
        end

        if (cfg.load)
        begin
            col_mod_next = cfg.col_mod;
            reduced_next = ({1'b0, row_reg} < cfg.factor);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            col_mod_reg  <= '0;
            row_reg      <= '0;
            reduced_reg  <= 1'b1;
            replays_reg  <= '0;
            rcol_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            col_mod_reg  <= col_mod_next;
            row_reg      <= row_next;
            reduced_reg  <= reduced_next;
            replays_reg  <= replays_next;
            rcol_reg     <= rcol_next;
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_job_reg <= jb;
        s1_mem_reg <= use_mem;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[col_reg] <= {pixel.red, pixel.green, pixel.blue};
    end

    always_ff @(posedge clk)
    begin
        if (use_mem)
            rd_data_reg <= line_mem[rcol_reg];
    end

    always_comb
    begin
        job = s1_job_reg;
        if (s1_mem_reg)
        begin
            job.red   = rd_data_reg[23:16];
            job.green = rd_data_reg[15:8];
            job.blue  = rd_data_reg[7:0];
        end
    end

    assign job_valid        = s1_valid_reg;
    assign status.column    = col_reg;
    assign status.row_phase = row_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nns_queue.sv
`default_nettype none

module nns_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire nns_pkg::job_t              push_job,
    input  wire logic                       pop,
    output logic                            head_valid,
    output nns_pkg::job_t                   head,
    output logic [nns_pkg::QCNT_W-1:0]      count
);
    import nns_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (!push && do_pop)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nns_back.sv
`default_nettype none

module nns_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire nns_pkg::job_t  head,
    output logic                pop,
    output logic                result_valid,
    input  wire logic           result_stall,
    output nns_pkg::out_item_t  result
);
    import nns_pkg::*;

    logic             cur_valid_reg;
    job_t             cur_job_reg;
    logic [FAC_W-1:0] left_reg;
    logic             last_beat;
    logic             take;
    logic             free;

    assign last_beat = (left_reg == FAC_W'(1));
    assign take      = cur_valid_reg && !result_stall;
    assign free      = !cur_valid_reg || (take && last_beat);
    assign pop       = free && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else if (free)
        begin
            cur_valid_reg <= head_valid;
            if (head_valid)
                left_reg <= head.count;
        end
        else if (take)
        begin
            left_reg <= left_reg - FAC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_job_reg <= head;
    end

    assign result_valid       = cur_valid_reg;
    assign result.out_blue    = cur_job_reg.blue;
    assign result.out_green   = cur_job_reg.green;
    assign result.out_red     = cur_job_reg.red;
    assign result.end_of_line = last_beat && cur_job_reg.eol;
    assign result.pad_bytes   = (last_beat && cur_job_reg.eol) ? cur_job_reg.pad : 2'd0;
    assign result.last        = last_beat;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_neighbor_image_scaler.sv
// Channel   Direction  Handshake                  Beat payload
// pixel     in         pixel_valid / pixel_stall  cmd, blue, green, red
// result    out        result_valid / result_stall out_blue .. last
// cfg       in         cfg_write                  cfg_index, cfg_data
//
// A beat is taken every cycle while the job queue has room and setup is idle.
// In enlarge mode a pixel or replay tick plays out as factor result beats,
// which slows intake once the queue fills; other beats go at one per cycle
// unless result_stall holds them. A result passes the read stage, queue and
// back's job register; a register write keeps setup busy. Reset clears the
// control state but not the line store, so a replay needs a line written first.
`default_nettype none

module nearest_neighbor_image_scaler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pixel_valid,
    output logic                                pixel_stall,
    input  wire nns_pkg::in_item_t              pixel,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output nns_pkg::out_item_t                  result,
    input  wire logic                           cfg_write,
    input  wire logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nns_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nns_pkg::*;

    cfg_t              cfg;
    fe_status_t        status;
    logic              job_valid;
    job_t              job;
    logic              head_valid;
    job_t              head;
    logic              pop;
    logic [QCNT_W-1:0] queue_count;

    // Holds the registers and derives the per-setting constants (column
    // phase, row wrap, last kept column, shrink pad) via a shared serial divider.
    nns_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cfg       (cfg)
    );

    // Front: accepts beats, tracks line position and replays, owns the
    // line store and turns each beat into at most one job.
    nns_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .pixel_stall (pixel_stall),
        .cfg         (cfg),
        .queue_count (queue_count),
        .status      (status),
        .job_valid   (job_valid),
        .job         (job)
    );

    // The queue lets the front keep accepting while a long run drains.
    nns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_job   (job),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (queue_count)
    );

    // Back: plays each job out as a run of identical beats, marking the
    // last beat and, on a line end, the pad count.
    nns_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/nns_checker.sv
`default_nettype none

module nns_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pixel_stall,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire nns_pkg::out_item_t result,
    input  wire logic               cfg_write
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    a_eol_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_line |-> result.last)
        else $error("line end on a beat that is not the last of its run");

    a_pad_only_eol: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_line |-> result.pad_bytes == 2'd0)
        else $error("pad count outside a line end");

    a_run_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=>
            result_valid && result.out_red == $past(result.out_red) &&
            result.out_green == $past(result.out_green) &&
            result.out_blue == $past(result.out_blue))
        else $error("run broken or pixel changed within a run");

    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> pixel_stall)
        else $error("pixel taken while settings are recomputed");

endmodule

bind nearest_neighbor_image_scaler nns_checker u_nns_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write)
);

`default_nettype wire
